@@ rtl/bank_switch_irq_mapper_top_macros.svh @@
// Assertion macros shared by the mapper checker
`ifndef BANK_SWITCH_IRQ_MAPPER_TOP_MACROS_SVH
`define BANK_SWITCH_IRQ_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BSIM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BSIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bsim_pkg.sv @@
// Types and constants shared by the mapper modules
package bsim_pkg;

	// Register groups selected by address bits 15..12
	localparam logic [3:0] GRP_PRG_LO    = 4'h8;
	localparam logic [3:0] GRP_PRG_HI    = 4'h9;
	localparam logic [3:0] GRP_CHR_FIRST = 4'hA;
	localparam logic [3:0] GRP_CHR_LAST  = 4'hD;
	localparam logic [3:0] GRP_CTRL      = 4'hE;
	localparam logic [3:0] GRP_IRQ       = 4'hF;

	// Register of the PRG pair that goes to the sound port
	localparam logic [1:0] PRG_SND_REG   = 2'd3;

	// CHR group offset inside the low two group bits
	localparam logic [1:0] CHR_GRP_BASE  = 2'd2;

	localparam logic [11:0] MASK_RESET   = 12'h010;

	localparam logic [7:0] PRG0_RESET    = 8'h00;
	localparam logic [7:0] PRG1_RESET    = 8'h01;
	localparam logic [7:0] PRG2_RESET    = 8'hFE;

	localparam logic [7:0] COUNT_TOP     = 8'hFF;

	localparam logic [9:0] PRESCALE_RELOAD = 10'd341;
	localparam logic [9:0] PRESCALE_STEP   = 10'd3;
	localparam logic [9:0] PRESCALE_WRAP   = PRESCALE_RELOAD - PRESCALE_STEP;

	// irq_control bits
	localparam int IRQ_REPEAT = 0;
	localparam int IRQ_ENABLE = 1;
	localparam int IRQ_CYCLE  = 2;

	typedef struct packed {
		logic       prg_we;
		logic [1:0] prg_idx;
		logic       chr_we;
		logic [2:0] chr_idx;
		logic       ctl_we;
		logic [7:0] data;
	} bank_wr_t;

	typedef struct packed {
		logic       tick;
		logic       ctl_we;
		logic       ack;
		logic       latch_we;
		logic [7:0] data;
	} irq_evt_t;

	typedef struct packed {
		logic [7:0] prg0;
		logic [7:0] prg1;
		logic [7:0] prg2;
		logic [7:0] chr;
		logic [7:0] ctl;
	} bank_view_t;

endpackage

@@ rtl/bsim_banks.sv @@
// PRG, CHR and control byte registers with post-update view
module bsim_banks (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsim_pkg::bank_wr_t   wr,
	input  logic [2:0]           slot,
	output bsim_pkg::bank_view_t view
);

	logic [7:0] prg_q [3];
	logic [7:0] prg_n [3];
	logic [7:0] chr_q [8];
	logic [7:0] chr_n [8];
	logic [7:0] ctl_q;
	logic [7:0] ctl_n;

	always_comb begin
		prg_n = prg_q;
		chr_n = chr_q;
		ctl_n = ctl_q;
		if (wr.prg_we) begin
			prg_n[wr.prg_idx] = wr.data;
		end
		if (wr.chr_we) begin
			chr_n[wr.chr_idx] = wr.data;
		end
		if (wr.ctl_we) begin
			ctl_n = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0] <= bsim_pkg::PRG0_RESET;
			prg_q[1] <= bsim_pkg::PRG1_RESET;
			prg_q[2] <= bsim_pkg::PRG2_RESET;
			for (int i = 0; i < 8; i++) begin
				chr_q[i] <= 8'(i);
			end
			ctl_q <= '0;
		end else begin
			prg_q <= prg_n;
			chr_q <= chr_n;
			ctl_q <= ctl_n;
		end
	end

	// Result reflects the state after this item
	always_comb begin
		view.prg0 = prg_n[0];
		view.prg1 = prg_n[1];
		view.prg2 = prg_n[2];
		view.chr  = chr_n[slot];
		view.ctl  = ctl_n;
	end

endmodule

@@ rtl/bsim_irq.sv @@
// IRQ latch, control, up-counter and scanline prescaler
module bsim_irq (
	input  logic               clk,
	input  logic               arst_n,
	input  bsim_pkg::irq_evt_t evt,
	output logic               line_n
);

	logic [7:0] latch_q;
	logic [7:0] latch_n;
	logic [2:0] ctl_q;
	logic [2:0] ctl_n;
	logic [7:0] count_q;
	logic [7:0] count_n;
	logic [9:0] pre_q;
	logic [9:0] pre_n;
	logic       line_q;
	logic       clk_cnt;

	always_comb begin
		latch_n = latch_q;
		ctl_n   = ctl_q;
		count_n = count_q;
		pre_n   = pre_q;
		line_n  = line_q;
		clk_cnt = 1'b0;
		if (evt.latch_we) begin
			latch_n = evt.data;
		end
		if (evt.ctl_we) begin
			ctl_n  = evt.data[2:0];
			line_n = 1'b0;
			if (evt.data[bsim_pkg::IRQ_ENABLE]) begin
				count_n = latch_q;
				pre_n   = bsim_pkg::PRESCALE_RELOAD;
			end
		end
		if (evt.ack) begin
			ctl_n[bsim_pkg::IRQ_ENABLE] = ctl_q[bsim_pkg::IRQ_REPEAT];
			line_n = 1'b0;
		end
		if (evt.tick && ctl_q[bsim_pkg::IRQ_ENABLE]) begin
			if (ctl_q[bsim_pkg::IRQ_CYCLE]) begin
				clk_cnt = 1'b1;
			end else if (pre_q <= bsim_pkg::PRESCALE_STEP) begin
				pre_n   = pre_q + bsim_pkg::PRESCALE_WRAP;
				clk_cnt = 1'b1;
			end else begin
				pre_n = pre_q - bsim_pkg::PRESCALE_STEP;
			end
		end
		// Overflow: reload and raise the line
		if (clk_cnt) begin
			if (count_q == bsim_pkg::COUNT_TOP) begin
				count_n = latch_q;
				line_n  = 1'b1;
			end else begin
				count_n = count_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			ctl_q   <= '0;
			count_q <= '0;
			pre_q   <= '0;
			line_q  <= 1'b0;
		end else begin
			latch_q <= latch_n;
			ctl_q   <= ctl_n;
			count_q <= count_n;
			pre_q   <= pre_n;
			line_q  <= line_n;
		end
	end

endmodule

@@ rtl/bank_switch_irq_mapper_top.sv @@
// Mapper top level: input register, decode, state update and result register
//
//   channel  handshake                   payload
//   item     item_valid / item_stall     kind cpu_addr write_data chr_slot
//   result   result_valid / result_stall irq_asserted prg_bank_* chr_bank
//                                        mirroring wram_enable sound_*
//   config   cfg_we                      cfg_data (a0 line mask)
//
// One item per cycle while the result side does not stall; an accepted item passes
// through the input register, then the result register, to the result ports.
// Decode and the bank/IRQ update sit in one combinational pass between them.
// Reset restores all banks, control and IRQ state at once; no clearing pass.
// A stalled result holds; the input register still takes an item whenever
// the result register is empty or is being taken.
module bank_switch_irq_mapper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [15:0] cpu_addr,
	input  logic [7:0]  write_data,
	input  logic [2:0]  chr_slot,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        irq_asserted,
	output logic [7:0]  prg_bank_first,
	output logic [7:0]  prg_bank_second,
	output logic [7:0]  prg_bank_third,
	output logic [7:0]  chr_bank,
	output logic [1:0]  mirroring,
	output logic        wram_enable,
	output logic        sound_mute,
	output logic        sound_write_valid,
	output logic [15:0] sound_reg_addr,
	output logic [7:0]  sound_write_data
);

	logic [11:0] mask_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic [2:0]  slot_s1;

	logic        valid_s2;
	logic        irq_s2;
	logic [7:0]  prg0_s2;
	logic [7:0]  prg1_s2;
	logic [7:0]  prg2_s2;
	logic [7:0]  chr_s2;
	logic [7:0]  ctl_s2;
	logic        snd_s2;
	logic [15:0] snd_addr_s2;
	logic [7:0]  snd_data_s2;

	logic                 advance;
	logic                 write_go;
	logic [3:0]           grp;
	logic                 odd;
	logic [1:0]           pair_reg;
	logic                 snd;
	logic                 irq_line_n;
	bsim_pkg::bank_wr_t   bank_wr;
	bsim_pkg::irq_evt_t   irq_evt;
	bsim_pkg::bank_view_t view;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= bsim_pkg::MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_data;
		end
	end

	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			kind_s1 <= kind;
			addr_s1 <= cpu_addr;
			data_s1 <= write_data;
			slot_s1 <= chr_slot;
		end
	end

	assign write_go = valid_s1 && advance && !kind_s1;
	assign grp      = addr_s1[15:12];
	assign odd      = |(addr_s1[11:0] & mask_q);
	assign pair_reg = {grp[0], odd};

	always_comb begin
		bank_wr       = '0;
		bank_wr.data  = data_s1;
		irq_evt       = '0;
		irq_evt.data  = data_s1;
		irq_evt.tick  = valid_s1 && advance && kind_s1;
		snd           = 1'b0;
		if (write_go) begin
			case (grp) inside
				bsim_pkg::GRP_PRG_LO, bsim_pkg::GRP_PRG_HI: begin
					if (pair_reg == bsim_pkg::PRG_SND_REG) begin
						snd = 1'b1;
					end else begin
						bank_wr.prg_we  = 1'b1;
						bank_wr.prg_idx = pair_reg;
					end
				end
				[bsim_pkg::GRP_CHR_FIRST:bsim_pkg::GRP_CHR_LAST]: begin
					bank_wr.chr_we  = 1'b1;
					bank_wr.chr_idx = {2'(grp[1:0] - bsim_pkg::CHR_GRP_BASE), odd};
				end
				bsim_pkg::GRP_CTRL: begin
					irq_evt.latch_we = odd;
					bank_wr.ctl_we   = !odd;
				end
				bsim_pkg::GRP_IRQ: begin
					irq_evt.ack    = odd;
					irq_evt.ctl_we = !odd;
				end
				default: begin
					// below 0x8000: drop
				end
			endcase
		end
	end

	bsim_banks u_banks (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (bank_wr),
		.slot   (slot_s1),
		.view   (view)
	);

	bsim_irq u_irq (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (irq_evt),
		.line_n (irq_line_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			irq_s2      <= irq_line_n;
			prg0_s2     <= view.prg0;
			prg1_s2     <= view.prg1;
			prg2_s2     <= view.prg2;
			chr_s2      <= view.chr;
			ctl_s2      <= view.ctl;
			snd_s2      <= snd;
			snd_addr_s2 <= snd ? addr_s1 : 16'd0;
			snd_data_s2 <= snd ? data_s1 : 8'd0;
		end
	end

	assign result_valid      = valid_s2;
	assign irq_asserted      = irq_s2;
	assign prg_bank_first    = prg0_s2;
	assign prg_bank_second   = prg1_s2;
	assign prg_bank_third    = prg2_s2;
	assign chr_bank          = chr_s2;
	assign mirroring         = ctl_s2[1:0];
	assign wram_enable       = ctl_s2[7];
	assign sound_mute        = ctl_s2[6];
	assign sound_write_valid = snd_s2;
	assign sound_reg_addr    = snd_addr_s2;
	assign sound_write_data  = snd_data_s2;

endmodule

@@ rtl/bsim_checker.sv @@
// Port-level checker for the mapper, bound to the top level
`include "bank_switch_irq_mapper_top_macros.svh"

module bsim_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic        sound_write_valid,
	input logic [15:0] sound_reg_addr,
	input logic [7:0]  sound_write_data
);

	// hold a stalled result
	`BSIM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "result dropped while stalled")

	// sound forwarding only ever comes from the 0x9000 group
	`BSIM_ASSERT_NOW(a_snd_group, result_valid && sound_write_valid, sound_reg_addr[15:12] == bsim_pkg::GRP_PRG_HI, "sound write outside 0x9000 group")

	// no sound write means zeroed sound payload
	`BSIM_ASSERT_NOW(a_snd_zero, result_valid && !sound_write_valid, sound_reg_addr == 16'd0 && sound_write_data == 8'd0, "sound payload not cleared")

	// with the result side free, the item side is never stalled
	`BSIM_ASSERT_NOW(a_no_false_stall, !result_valid || !result_stall, !item_stall, "item stalled while result side free")

endmodule

bind bank_switch_irq_mapper_top bsim_checker u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_stall        (item_stall),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.sound_write_valid (sound_write_valid),
	.sound_reg_addr    (sound_reg_addr),
	.sound_write_data  (sound_write_data)
);

@@ tb/sv/bank_switch_irq_mapper_top_test.sv @@
// Self-checking testbench for the bank-switching IRQ mapper: directed table, then random traffic
`timescale 1ns / 1ps

module bank_switch_irq_mapper_top_test;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   DRAIN_CYCLES = 4;
	localparam int   RANDOM_PER_PHASE = 170;

	typedef struct packed {
		logic        kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [2:0]  slot;
	} mapper_item_t;

	// field order matches the result ports
	typedef struct packed {
		logic        irq;
		logic [7:0]  prg0;
		logic [7:0]  prg1;
		logic [7:0]  prg2;
		logic [7:0]  chr;
		logic [1:0]  mirror;
		logic        wram;
		logic        mute;
		logic        snd_we;
		logic [15:0] snd_addr;
		logic [7:0]  snd_data;
	} bank_result_t;

	typedef struct packed {
		logic         typed;
		mapper_item_t it;
		bank_result_t want;
	} table_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [11:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        kind = 1'b0;
	logic [15:0] cpu_addr = '0;
	logic [7:0]  write_data = '0;
	logic [2:0]  chr_slot = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        irq_asserted;
	logic [7:0]  prg_bank_first;
	logic [7:0]  prg_bank_second;
	logic [7:0]  prg_bank_third;
	logic [7:0]  chr_bank;
	logic [1:0]  mirroring;
	logic        wram_enable;
	logic        sound_mute;
	logic        sound_write_valid;
	logic [15:0] sound_reg_addr;
	logic [7:0]  sound_write_data;

	bank_switch_irq_mapper_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.cpu_addr         (cpu_addr),
		.write_data       (write_data),
		.chr_slot         (chr_slot),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.irq_asserted     (irq_asserted),
		.prg_bank_first   (prg_bank_first),
		.prg_bank_second  (prg_bank_second),
		.prg_bank_third   (prg_bank_third),
		.chr_bank         (chr_bank),
		.mirroring        (mirroring),
		.wram_enable      (wram_enable),
		.sound_mute       (sound_mute),
		.sound_write_valid(sound_write_valid),
		.sound_reg_addr   (sound_reg_addr),
		.sound_write_data (sound_write_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// mapper state mirror
	logic [11:0] mask_q;
	logic [7:0]  prg_q [3];
	logic [7:0]  chr_q [8];
	logic [7:0]  ctl_q;
	logic [7:0]  latch_q;
	logic [2:0]  irqc_q;
	logic [7:0]  count_q;
	logic [9:0]  presc_q;
	logic        line_q;

	bank_result_t pending_results[$];
	table_row_t   dir_rows[$];
	int fail_count = 0;
	int sent_items = 0;
	int burst_left = 0;
	int cycle_count = 0;

	function automatic void clock_irq_counter();
		if (count_q == bsim_pkg::COUNT_TOP) begin
			count_q = latch_q;
			line_q = 1'b1;
		end else begin
			count_q = count_q + 8'd1;
		end
	endfunction

	function automatic bank_result_t apply_item(input mapper_item_t it);
		logic [3:0]   grp;
		logic         odd;
		logic         snd;
		logic [1:0]   prg_idx;
		logic [1:0]   chr_grp;
		bank_result_t r;
		snd = 1'b0;
		grp = it.addr[15:12];
		odd = |(it.addr[11:0] & mask_q);
		if (it.kind == KIND_TICK) begin
			if (irqc_q[bsim_pkg::IRQ_ENABLE]) begin
				if (irqc_q[bsim_pkg::IRQ_CYCLE]) begin
					clock_irq_counter();
				end else if (presc_q <= bsim_pkg::PRESCALE_STEP) begin
					presc_q = presc_q + bsim_pkg::PRESCALE_WRAP;
					clock_irq_counter();
				end else begin
					presc_q = presc_q - bsim_pkg::PRESCALE_STEP;
				end
			end
		end else if (grp == bsim_pkg::GRP_PRG_LO || grp == bsim_pkg::GRP_PRG_HI) begin
			prg_idx = {grp[0], odd};
			if (prg_idx == bsim_pkg::PRG_SND_REG)
				snd = 1'b1;
			else
				prg_q[prg_idx] = it.data;
		end else if (grp >= bsim_pkg::GRP_CHR_FIRST && grp <= bsim_pkg::GRP_CHR_LAST) begin
			chr_grp = grp[1:0] - bsim_pkg::CHR_GRP_BASE;
			chr_q[{chr_grp, odd}] = it.data;
		end else if (grp == bsim_pkg::GRP_CTRL) begin
			if (odd)
				latch_q = it.data;
			else
				ctl_q = it.data;
		end else if (grp == bsim_pkg::GRP_IRQ) begin
			if (odd) begin
				// acknowledge: repeat bit becomes the enable
				irqc_q[bsim_pkg::IRQ_ENABLE] = irqc_q[bsim_pkg::IRQ_REPEAT];
			end else begin
				irqc_q = it.data[2:0];
				if (irqc_q[bsim_pkg::IRQ_ENABLE]) begin
					count_q = latch_q;
					presc_q = bsim_pkg::PRESCALE_RELOAD;
				end
			end
			line_q = 1'b0;
		end
		r.irq      = line_q;
		r.prg0     = prg_q[0];
		r.prg1     = prg_q[1];
		r.prg2     = prg_q[2];
		r.chr      = chr_q[it.slot];
		r.mirror   = ctl_q[1:0];
		r.wram     = ctl_q[7];
		r.mute     = ctl_q[6];
		r.snd_we   = snd;
		r.snd_addr = snd ? it.addr : 16'h0000;
		r.snd_data = snd ? it.data : 8'h00;
		return r;
	endfunction

	function automatic mapper_item_t make_write(input logic [3:0] grp, input logic odd,
			input logic [7:0] data);
		mapper_item_t it;
		logic [11:0]  low;
		low = 12'($urandom_range(0, 4095));
		it.kind = KIND_WRITE;
		it.addr = {grp, odd ? (low | mask_q) : (low & ~mask_q)};
		it.data = data;
		it.slot = 3'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic mapper_item_t make_tick();
		mapper_item_t it;
		it.kind = KIND_TICK;
		it.addr = 16'($urandom_range(0, 65535));
		it.data = 8'($urandom_range(0, 255));
		it.slot = 3'($urandom_range(0, 7));
		return it;
	endfunction

	function automatic mapper_item_t random_item();
		int           r;
		mapper_item_t it;
		r = $urandom_range(0, 99);
		if (r < 45)
			return make_tick();
		if (r < 60)
			return make_write(4'($urandom_range(bsim_pkg::GRP_PRG_LO, bsim_pkg::GRP_PRG_HI)),
				1'($urandom), 8'($urandom));
		if (r < 75)
			return make_write(
				4'($urandom_range(bsim_pkg::GRP_CHR_FIRST, bsim_pkg::GRP_CHR_LAST)),
				1'($urandom), 8'($urandom));
		if (r < 85)
			return make_write(bsim_pkg::GRP_CTRL, 1'($urandom), 8'($urandom));
		if (r < 95)
			return make_write(bsim_pkg::GRP_IRQ, 1'($urandom), 8'($urandom));
		// any address, the low half of the map included
		it = make_tick();
		it.kind = KIND_WRITE;
		return it;
	endfunction

	task automatic add_row(input logic k, input logic [15:0] a, input logic [7:0] d,
			input logic [2:0] s, input logic typed, input bank_result_t want);
		table_row_t row;
		row.typed = typed;
		row.it = {k, a, d, s};
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input mapper_item_t it, input logic typed,
			input bank_result_t want);
		int           gap;
		bank_result_t pred;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		kind <= it.kind;
		cpu_addr <= it.addr;
		write_data <= it.data;
		chr_slot <= it.slot;
		do @(posedge clk); while (item_stall);
		pred = apply_item(it);
		pending_results.push_back(typed ? want : pred);
		sent_items++;
	endtask

	task automatic wait_idle();
		@(negedge clk) item_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mask(input logic [11:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk) cfg_we <= 1'b0;
		mask_q = value;
	endtask

	// latch, arm, then a long run of ticks with stray writes mixed in
	task automatic irq_sequence();
		int          n;
		logic [7:0]  ctl;
		mapper_item_t it;
		send_item(make_write(bsim_pkg::GRP_CTRL, 1'b1, ($urandom_range(0, 1) == 1) ?
			8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom)), 1'b0, '0);
		ctl = 8'($urandom);
		if ($urandom_range(0, 9) != 0)
			ctl[bsim_pkg::IRQ_ENABLE] = 1'b1;
		send_item(make_write(bsim_pkg::GRP_IRQ, 1'b0, ctl), 1'b0, '0);
		n = $urandom_range(10, 300);
		repeat (n) begin
			it = ($urandom_range(0, 19) == 0) ? random_item() : make_tick();
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		bank_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				cmp_field("irq_asserted", want.irq, irq_asserted);
				cmp_field("prg_bank_first", want.prg0, prg_bank_first);
				cmp_field("prg_bank_second", want.prg1, prg_bank_second);
				cmp_field("prg_bank_third", want.prg2, prg_bank_third);
				cmp_field("chr_bank", want.chr, chr_bank);
				cmp_field("mirroring", want.mirror, mirroring);
				cmp_field("wram_enable", want.wram, wram_enable);
				cmp_field("sound_mute", want.mute, sound_mute);
				cmp_field("sound_write_valid", want.snd_we, sound_write_valid);
				cmp_field("sound_reg_addr", want.snd_addr, sound_reg_addr);
				cmp_field("sound_write_data", want.snd_data, sound_write_data);
			end
		end
	end

	// receiver back-pressure: switch between free, light, heavy and periodic stalling
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(32, 256);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: result_stall <= ((stall_phase % 5) < 2);
		endcase
		stall_phase <= stall_phase + 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [11:0] masks [6];
		int          phase_end;
		mask_q = bsim_pkg::MASK_RESET;
		prg_q[0] = bsim_pkg::PRG0_RESET;
		prg_q[1] = bsim_pkg::PRG1_RESET;
		prg_q[2] = bsim_pkg::PRG2_RESET;
		for (int i = 0; i < 8; i++)
			chr_q[i] = 8'(i);
		ctl_q = '0;
		latch_q = '0;
		irqc_q = '0;
		count_q = '0;
		presc_q = '0;
		line_q = 1'b0;

		// result order: irq prg0 prg1 prg2 chr mirror wram mute snd_we snd_addr snd_data
		add_row(KIND_TICK,  16'h0000, 8'h00, 3'd7, 1'b1,
			{1'b0, 8'h00, 8'h01, 8'hFE, 8'h07, 2'd0, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00});
		add_row(KIND_WRITE, 16'h7FFF, 8'hFF, 3'd0, 1'b1,
			{1'b0, 8'h00, 8'h01, 8'hFE, 8'h00, 2'd0, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00});
		add_row(KIND_WRITE, 16'h9010, 8'hA5, 3'd3, 1'b1,
			{1'b0, 8'h00, 8'h01, 8'hFE, 8'h03, 2'd0, 1'b0, 1'b0, 1'b1, 16'h9010, 8'hA5});
		add_row(KIND_WRITE, 16'h8000, 8'hFF, 3'd0, 1'b0, '0);
		add_row(KIND_WRITE, 16'h8010, 8'h00, 3'd0, 1'b0, '0);
		add_row(KIND_WRITE, 16'h9000, 8'h80, 3'd0, 1'b0, '0);
		add_row(KIND_WRITE, 16'hA000, 8'hFF, 3'd0, 1'b0, '0);
		add_row(KIND_WRITE, 16'hA010, 8'h00, 3'd1, 1'b0, '0);
		add_row(KIND_WRITE, 16'hB000, 8'h12, 3'd2, 1'b0, '0);
		add_row(KIND_WRITE, 16'hD010, 8'h7F, 3'd7, 1'b0, '0);
		add_row(KIND_WRITE, 16'hE000, 8'hC3, 3'd7, 1'b0, '0);
		add_row(KIND_WRITE, 16'hE010, 8'hFE, 3'd4, 1'b0, '0);
		add_row(KIND_WRITE, 16'hF000, 8'h07, 3'd5, 1'b0, '0);
		add_row(KIND_TICK,  16'hFFFF, 8'hFF, 3'd6, 1'b0, '0);
		add_row(KIND_TICK,  16'h1234, 8'h5A, 3'd7, 1'b0, '0);
		add_row(KIND_WRITE, 16'hF010, 8'h00, 3'd0, 1'b0, '0);
		add_row(KIND_TICK,  16'h0000, 8'h00, 3'd1, 1'b0, '0);
		add_row(KIND_TICK,  16'h0000, 8'h00, 3'd2, 1'b0, '0);
		add_row(KIND_WRITE, 16'hF000, 8'h02, 3'd3, 1'b0, '0);
		add_row(KIND_TICK,  16'h8000, 8'h00, 3'd3, 1'b0, '0);
		add_row(KIND_WRITE, 16'hFFFF, 8'h00, 3'd4, 1'b0, '0);
		add_row(KIND_TICK,  16'hAAAA, 8'h55, 3'd4, 1'b0, '0);
		add_row(KIND_WRITE, 16'h9FFF, 8'h55, 3'd5, 1'b0, '0);
		add_row(KIND_WRITE, 16'hE000, 8'h00, 3'd6, 1'b0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		masks[0] = 12'h001;
		masks[1] = 12'hFFF;
		masks[2] = 12'h800;
		masks[3] = 12'($urandom_range(1, 4095));
		masks[4] = bsim_pkg::MASK_RESET;
		masks[5] = 12'($urandom_range(1, 4095));
		foreach (masks[p]) begin
			write_mask(masks[p]);
			phase_end = sent_items + RANDOM_PER_PHASE;
			while (sent_items < phase_end) begin
				if ($urandom_range(0, 99) < 12)
					irq_sequence();
				else
					send_item(random_item(), 1'b0, '0);
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
